// ===== hw/rtl/opd_pkg.sv =====
// Package for the order-preserving dedup core: beat types, probe type, defaults.
// No dependencies; used by opd_cell and order_preserving_dedup_core.
package opd_pkg;

  localparam int unsigned DefaultDepth = 64;
  localparam int unsigned ValueW       = 32;
  localparam int unsigned CountOutW    = 7;

  // Input beat
  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     last;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic signed [ValueW-1:0] out_value;
    logic                     keep;
    logic [CountOutW-1:0]     distinct_count;
    logic                     out_last;
    logic                     overflow;
  } out_item_t;

  // Search token that walks the cell row
  typedef struct packed {
    logic                     valid;
    logic signed [ValueW-1:0] value;
    logic                     last;
    logic                     hit;
  } probe_t;

endpackage

// ===== hw/rtl/opd_cell.sv =====
// One table cell: holds a stored value and passes the search token to its neighbor.
// Depends on opd_pkg.
module opd_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 7
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          advance_i,
  input  opd_pkg::probe_t               probe_i,
  output opd_pkg::probe_t               probe_o,
  input  logic                          wr_en_i,
  input  logic signed [opd_pkg::ValueW-1:0] wr_value_i,
  input  logic [CNT_W-1:0]              count_i
);

  logic signed [opd_pkg::ValueW-1:0] entry_q;
  logic                              probe_vld_q;
  opd_pkg::probe_t                   probe_q;
  logic                              occupied;
  logic                              match;

  // Entry is live only below the fill count
  assign occupied = count_i > CNT_W'(IDX);
  assign match    = occupied && (entry_q == probe_i.value);

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (count_i == CNT_W'(IDX))) begin
      entry_q <= wr_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_vld_q <= 1'b0;
    end else if (advance_i) begin
      probe_vld_q <= probe_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      probe_q.valid <= 1'b0;
      probe_q.value <= probe_i.value;
      probe_q.last  <= probe_i.last;
      probe_q.hit   <= probe_i.hit | match;
    end
  end

  always_comb begin
    probe_o       = probe_q;
    probe_o.valid = probe_vld_q;
  end

endmodule

// ===== hw/rtl/order_preserving_dedup_core.sv =====
// Top level of the order-preserving dedup core: cell row, fill count, result register.
// Depends on opd_pkg and opd_cell.
//
// Usage:
//   Input channel in_valid_i / in_stall_o / in_item_i carries one signed value
//   per beat plus a last flag marking the end of an array. Output channel
//   out_valid_o / out_stall_i / out_item_o returns one result beat per input:
//   the value, keep (first occurrence), running distinct count, last echo and
//   overflow (new value, table full, not stored).
//   A search token walks a row of DEPTH cells, one cell per cycle while the row
//   is not held, each cell comparing against its stored value. The result is
//   registered in the result register ahead of out_item_o, and the next input
//   beat is taken only after the item has left the last cell.
//   Only one item is in the row at a time; in_stall_o is high while it walks.
//   The result register lets a new item enter while the previous result is
//   still stalled. If a second result finishes while the register is full,
//   the token holds in the last cell until out_stall_i drops.
//   Reset clears the fill count, the token and the result valid flag; table
//   contents need no clearing. The fill count returns to zero after a last beat.
module order_preserving_dedup_core #(
  parameter int unsigned DEPTH = opd_pkg::DefaultDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  opd_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output opd_pkg::out_item_t  out_item_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  opd_pkg::probe_t     probe [0:DEPTH];
  logic [DEPTH-1:0]    probe_vld;
  logic [CntW-1:0]     count_q, count_d;
  logic                busy_q, busy_d;
  logic                out_valid_q, out_valid_d;
  opd_pkg::out_item_t  out_item_q, out_item_d;
  logic                in_accept;
  logic                transfer;
  logic                advance;
  logic                keep;
  logic                room;
  logic                store;
  logic [CntW-1:0]     new_count;
  opd_pkg::probe_t     tail;

  assign in_stall_o = busy_q;
  assign in_accept  = in_valid_i && !busy_q;

  always_comb begin
    probe[0].valid = in_accept;
    probe[0].value = in_item_i.value;
    probe[0].last  = in_item_i.last;
    probe[0].hit   = 1'b0;
  end

  assign tail     = probe[DEPTH];
  assign transfer = tail.valid && (!out_valid_q || !out_stall_i);
  // Hold the whole row while a finished token waits on the result register
  assign advance  = !(tail.valid && !transfer);

  assign keep      = !tail.hit;
  assign room      = count_q < CntW'(DEPTH);
  assign store     = transfer && keep && room;
  assign new_count = store ? count_q + CntW'(1) : count_q;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    opd_cell #(
      .IDX   (i),
      .CNT_W (CntW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .advance_i  (advance),
      .probe_i    (probe[i]),
      .probe_o    (probe[i+1]),
      .wr_en_i    (store),
      .wr_value_i (tail.value),
      .count_i    (count_q)
    );
    assign probe_vld[i] = probe[i+1].valid;
  end

  always_comb begin
    busy_d      = busy_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (in_accept) begin
      busy_d = 1'b1;
    end
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (transfer) begin
      busy_d                    = 1'b0;
      out_valid_d               = 1'b1;
      out_item_d.out_value      = tail.value;
      out_item_d.keep           = keep;
      out_item_d.distinct_count = opd_pkg::CountOutW'(new_count);
      out_item_d.out_last       = tail.last;
      out_item_d.overflow       = keep && !room;
      // Clear the table at the end of an array
      count_d                   = tail.last ? '0 : new_count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Fill count never passes the table size
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("fill count exceeds table depth");

  // At most one token in the row, and only while busy
  a_single_token : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(probe_vld) && (busy_q || (probe_vld == '0)))
    else $error("token in cell row without an item in flight");

  // Overflow only on a kept value
  a_ovf_keep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_item_q.overflow |-> out_item_q.keep)
    else $error("overflow flagged on a duplicate");

  // A completed item frees the input on the next cycle
  a_release : assert property (@(posedge clk_i) disable iff (!rst_ni)
    transfer |=> !busy_q && out_valid_q)
    else $error("input not released after result capture");

endmodule

// ===== test/order_preserving_dedup_checker.sv =====
// Checker for the order-preserving dedup core: watches both channels, predicts each result
// from its own copy of the seen-value table and compares beat by beat.
// Depends on opd_pkg.
`timescale 1ns / 100ps

module order_preserving_dedup_checker #(
  parameter int unsigned DEPTH = opd_pkg::DefaultDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  opd_pkg::in_item_t  in_item_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  opd_pkg::out_item_t out_item_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  logic signed [opd_pkg::ValueW-1:0] seen_tbl [DEPTH];
  int unsigned                        seen_fill;
  opd_pkg::out_item_t                 expected_results [$];

  function automatic opd_pkg::out_item_t dedup_predict(input opd_pkg::in_item_t beat);
    opd_pkg::out_item_t res;
    logic               hit;
    hit = 1'b0;
    for (int i = 0; i < seen_fill; i++) begin
      if (seen_tbl[i] == beat.value) hit = 1'b1;
    end
    res.out_value = beat.value;
    res.keep      = !hit;
    res.overflow  = 1'b0;
    if (!hit) begin
      if (seen_fill < DEPTH) begin
        seen_tbl[seen_fill] = beat.value;
        seen_fill++;
      end else begin
        res.overflow = 1'b1;
      end
    end
    // count field keeps only its low bits
    res.distinct_count = opd_pkg::CountOutW'(seen_fill);
    res.out_last       = beat.last;
    if (beat.last) seen_fill = 0;
    return res;
  endfunction

  task automatic check_field(input string field, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    opd_pkg::out_item_t want;
    if (!rst_ni) begin
      expected_results.delete();
      seen_fill    = 0;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with nothing pending, expected none, actual value %0d",
                   $time, out_item_i.out_value);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          check_field("out_value", want.out_value, out_item_i.out_value);
          check_field("keep", want.keep, out_item_i.keep);
          check_field("distinct_count", want.distinct_count, out_item_i.distinct_count);
          check_field("out_last", want.out_last, out_item_i.out_last);
          check_field("overflow", want.overflow, out_item_i.overflow);
        end
      end
      if (in_valid_i && !in_stall_i) expected_results.push_back(dedup_predict(in_item_i));
      pending_o = expected_results.size();
    end
  end

endmodule

// ===== test/order_preserving_dedup_core_tb.sv =====
// Testbench top for the order-preserving dedup core: clock, reset, stimulus and verdict.
// Depends on opd_pkg, order_preserving_dedup_core and order_preserving_dedup_checker.
`timescale 1ns / 100ps

module order_preserving_dedup_core_tb;

  localparam int unsigned DEPTH       = opd_pkg::DefaultDepth;
  localparam int          CYCLE_LIMIT = 500000;
  localparam int          ITEM_GOAL   = 800;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  opd_pkg::in_item_t  in_item_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  opd_pkg::out_item_t out_item_o;

  int fail_count;
  int pending;
  int cycles        = 0;
  int items_sent    = 0;
  bit quiet         = 1'b0;
  bit long_hold_go  = 1'b0;
  bit long_hold_done = 1'b0;

  order_preserving_dedup_core #(.DEPTH(DEPTH)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  order_preserving_dedup_checker #(.DEPTH(DEPTH)) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_i   (out_item_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one beat and hold it until accepted; sometimes drop valid for a short burst after.
  task automatic send_beat(input logic signed [opd_pkg::ValueW-1:0] v, input logic lst);
    opd_pkg::in_item_t beat;
    beat.value = v;
    beat.last  = lst;
    in_valid_i <= 1'b1;
    in_item_i  <= beat;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  // Receiver: random stall bursts, one long hold-off on request, none once quiet.
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold_go && !long_hold_done) begin
        out_stall_i <= 1'b1;
        repeat (600) @(posedge clk_i);
        out_stall_i <= 1'b0;
        long_hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    logic signed [opd_pkg::ValueW-1:0] pool [6];
    logic signed [opd_pkg::ValueW-1:0] base;
    logic signed [opd_pkg::ValueW-1:0] v;
    int  len;
    int  pick;
    int  wide_arrays;
    bit  noise;
    bit  drained;

    wide_arrays = 0;
    drained     = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single-element array at the negative extreme
    send_beat(32'sh8000_0000, 1'b1);
    // extremes, a duplicate of the positive one, and a duplicate on the last beat
    send_beat(32'sh7fff_ffff, 1'b0);
    send_beat(32'sh8000_0000, 1'b0);
    send_beat(32'sh0000_0000, 1'b0);
    send_beat(-32'sd1, 1'b0);
    send_beat(32'sh7fff_ffff, 1'b0);
    send_beat(-32'sd1, 1'b0);
    send_beat(32'sd1, 1'b0);
    send_beat(32'sh0000_0000, 1'b1);
    // alternating bit patterns, then a run of repeats
    send_beat(32'sh5555_5555, 1'b0);
    send_beat(32'shaaaa_aaaa, 1'b0);
    send_beat(32'sd5, 1'b0);
    send_beat(32'sd5, 1'b0);
    send_beat(32'sd5, 1'b1);
    // same value in back-to-back arrays: table must clear at last
    send_beat(32'sd7, 1'b1);
    send_beat(32'sd7, 1'b1);
    send_beat(32'sd3, 1'b0);
    send_beat(32'sd3, 1'b0);
    send_beat(32'sd3, 1'b1);

    while (items_sent < ITEM_GOAL) begin
      if (items_sent >= 300) long_hold_go = 1'b1;
      if (items_sent >= 500 && !drained) begin
        // pause until every result is back
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        wait (pending == 0);
        @(posedge clk_i);
        drained = 1'b1;
      end
      if (items_sent >= 700) quiet = 1'b1;

      if (wide_arrays < 4 && items_sent >= 150 * (wide_arrays + 1)) begin
        // fill the table: first time exactly to the brim, later past it
        len  = (wide_arrays == 0) ? DEPTH : DEPTH + $urandom_range(1, 10);
        base = $urandom();
        for (int i = 0; i < len; i++) send_beat(base + i, 1'b0);
        for (int k = 0; k < 6; k++) send_beat(base + $urandom_range(0, len - 1), 1'b0);
        send_beat(base + $urandom_range(0, len + 2), 1'b1);
        wide_arrays++;
      end else begin
        pick  = $urandom_range(0, 99);
        noise = (pick >= 80);
        len   = $urandom_range(1, 24);
        for (int j = 0; j < 6; j++) pool[j] = $urandom();
        for (int i = 0; i < len; i++) begin
          v = (noise || $urandom_range(0, 2) == 0) ? $urandom() : pool[$urandom_range(0, 5)];
          send_beat(v, i == len - 1);
        end
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (DEPTH + 8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
